### src/are_pkg.sv
package are_pkg;

  // Gain is unsigned fixed point, FRAC_W fraction bits; unity needs one more bit.
  localparam int FRAC_W = 16;
  localparam int GAIN_W = FRAC_W + 1;
  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1) << FRAC_W;

  // Step counter covers the longest serial pass (the multiply).
  localparam int STEP_W = $clog2(GAIN_W);

  typedef logic [1:0] phase_t;
  localparam phase_t PHASE_ATTACK  = 2'd0;
  localparam phase_t PHASE_RELEASE = 2'd1;
  localparam phase_t PHASE_OFF     = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd1;

endpackage

### src/attack_release_envelope_core.sv
// Each accepted input beat passes through a 16-step restoring divider (one quotient bit
// per cycle) and a 17-step shift-add multiplier (one gain bit per cycle) before out_tvalid;
// a new beat is accepted only once the previous result has entered the output register.
// A new beat is taken while the previous result still waits in the output register.
// Reset (synchronous, rst_n low): position, attack and release lengths clear to zero,
// the sequencer returns to idle and the output register empties.
module attack_release_envelope_core
  import are_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COUNT_WIDTH  = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     in_tdata,  // sample_in
  input  logic                                  in_tuser,  // start_req
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     out_tdata, // sample_out
  input  logic                                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [COUNT_WIDTH-1:0]                cfg_data
);

  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int POS_W   = COUNT_WIDTH + 1;
  localparam int ACC_W   = SAMPLE_WIDTH + GAIN_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_GAIN = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(FRAC_W - 1);
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(GAIN_W - 1);

  logic [2:0]                     state_r, state_nxt;
  logic [STEP_W-1:0]              step_r, step_nxt;
  logic [COUNT_WIDTH-1:0]         attack_r, release_r;
  logic [POS_W-1:0]               pos_r, pos_nxt;
  phase_t                         phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0]         rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0]         div_r, div_nxt;
  logic [FRAC_W-1:0]              quo_r, quo_nxt;
  logic [GAIN_W-1:0]              gain_r, gain_nxt;
  logic signed [SAMPLE_WIDTH-1:0] sample_r, sample_nxt;
  logic signed [ACC_W-1:0]        acc_r, acc_nxt;
  logic                           out_tvalid_r, out_tvalid_nxt;
  logic [TDATA_W-1:0]             out_tdata_r, out_tdata_nxt;

  logic                   in_beat;
  logic [POS_W-1:0]       n_pos;
  logic [POS_W-1:0]       attack_ext;
  logic [POS_W-1:0]       total;
  logic [POS_W-1:0]       rel_off;
  logic [POS_W-1:0]       rem_dbl;
  logic [POS_W-1:0]       rem_sub;
  logic                   out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_free   = !out_tvalid_r || out_tready;

  assign n_pos      = in_tuser ? '0 : pos_r;
  assign attack_ext = {1'b0, attack_r};
  assign total      = attack_ext + {1'b0, release_r};
  assign rel_off    = n_pos - attack_ext;

  assign rem_dbl = {rem_r, 1'b0};
  assign rem_sub = rem_dbl - {1'b0, div_r};

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    pos_nxt        = pos_r;
    phase_nxt      = phase_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    quo_nxt        = quo_r;
    gain_nxt       = gain_r;
    sample_nxt     = sample_r;
    acc_nxt        = acc_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          sample_nxt = in_tdata[SAMPLE_WIDTH-1:0];
          step_nxt   = '0;
          quo_nxt    = '0;
          if (n_pos < attack_ext) begin
            phase_nxt = PHASE_ATTACK;
            rem_nxt   = n_pos[COUNT_WIDTH-1:0];
            div_nxt   = attack_r;
          end else if (n_pos < total) begin
            phase_nxt = PHASE_RELEASE;
            rem_nxt   = rel_off[COUNT_WIDTH-1:0];
            div_nxt   = release_r;
          end else begin
            phase_nxt = PHASE_OFF;
            rem_nxt   = '0;
            div_nxt   = '0;
          end
          // advance, saturating at the end of the envelope
          pos_nxt   = (n_pos < total) ? n_pos + POS_W'(1) : n_pos;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // one quotient bit per beat of the clock: shift, compare, subtract
        if (!rem_sub[POS_W-1]) begin
          rem_nxt = rem_sub[COUNT_WIDTH-1:0];
          quo_nxt = {quo_r[FRAC_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_dbl[COUNT_WIDTH-1:0];
          quo_nxt = {quo_r[FRAC_W-2:0], 1'b0};
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == DIV_LAST) begin
          state_nxt = ST_GAIN;
        end
      end
      ST_GAIN: begin
        case (phase_r)
          PHASE_ATTACK:  gain_nxt = {1'b0, quo_r};
          PHASE_RELEASE: gain_nxt = UNITY_GAIN - {1'b0, quo_r};
          default:       gain_nxt = '0;
        endcase
        acc_nxt   = '0;
        step_nxt  = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        // MSB-first shift-add over the gain bits
        acc_nxt  = (acc_r <<< 1) + (gain_r[GAIN_W-1] ? ACC_W'(sample_r) : ACC_W'(0));
        gain_nxt = {gain_r[GAIN_W-2:0], 1'b0};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == MUL_LAST) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the output register can take the result
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = TDATA_W'(acc_r[FRAC_W+SAMPLE_WIDTH-1:FRAC_W]);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      pos_r        <= '0;
      attack_r     <= '0;
      release_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      pos_r        <= pos_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en && cfg_index == REG_ATTACK) begin
        attack_r <= cfg_data;
      end
      if (cfg_wr_en && cfg_index == REG_RELEASE) begin
        release_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    phase_r     <= phase_nxt;
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    quo_r       <= quo_nxt;
    gain_r      <= gain_nxt;
    sample_r    <= sample_nxt;
    acc_r       <= acc_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule
